// File: hw/rtl/sawbc_pkg.sv
package sawbc_pkg;

	localparam int NUM_SETS   = 8;
	localparam int NUM_WAYS   = 6;
	localparam int LINE_BYTES = 4;
	localparam int MEM_BYTES  = 65536;

	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int OFF_W     = $clog2(LINE_BYTES);
	localparam int SET_W     = $clog2(NUM_SETS);
	localparam int TAG_W     = ADDR_W - OFF_W - SET_W;
	localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int NUM_LINES = NUM_SETS * NUM_WAYS;
	localparam int LIDX_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int LINE_W    = 8 * LINE_BYTES;
	localparam int MEM_ROWS  = MEM_BYTES / LINE_BYTES;
	localparam int ROW_W     = ADDR_W - OFF_W;
	localparam int AGE_W     = 16;
	localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WB_RD,
		ST_WB,
		ST_FILL_RD,
		ST_FILL,
		ST_LINE_RD,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic lookup;
		logic line_rd;
		logic mem_wr;
		logic mem_rd;
		logic fill;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hit;
		logic need_wb;
		logic is_write;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: hw/rtl/sawbc_ctrl.sv
module sawbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sawbc_pkg::dp_stat_t stat,
	output sawbc_pkg::dp_cmd_t  cmd
);
	import sawbc_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (stat.hit)          state_nxt = ST_LINE_RD;
				else if (stat.need_wb) state_nxt = ST_WB_RD;
				else                   state_nxt = ST_FILL_RD;
			end
			ST_WB_RD: begin
				cmd.line_rd = 1'b1;
				state_nxt   = ST_WB;
			end
			ST_WB: begin
				cmd.mem_wr = 1'b1;
				state_nxt  = ST_FILL_RD;
			end
			ST_FILL_RD: begin
				cmd.mem_rd = 1'b1;
				state_nxt  = ST_FILL;
			end
			ST_FILL: begin
				cmd.fill  = 1'b1;
				state_nxt = ST_LINE_RD;
			end
			ST_LINE_RD: begin
				cmd.line_rd = 1'b1;
				state_nxt   = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold a read while the previous result is still unclaimed; a write goes on
				if (stat.is_write || !stat.out_busy) begin
					cmd.update = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

endmodule

// File: hw/rtl/sawbc_dp.sv
module sawbc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sawbc_pkg::dp_cmd_t                   cmd,
	output sawbc_pkg::dp_stat_t                  stat,
	input  logic                                 in_cmd,
	input  logic [sawbc_pkg::IN_DATA_W-1:0]      in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sawbc_pkg::OUT_DATA_W-1:0]     out_data
);
	import sawbc_pkg::*;

	logic                 cmd_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [7:0]           wdata_q;
	logic [WAY_W-1:0]     way_q;
	logic                 hit_q;
	logic [TAG_W-1:0]     old_tag_q;

	logic [NUM_WAYS-1:0][TAG_W-1:0] tag_q   [NUM_SETS];
	logic [NUM_WAYS-1:0]            valid_q [NUM_SETS];
	logic [NUM_WAYS-1:0]            dirty_q [NUM_SETS];
	logic [NUM_WAYS-1:0][AGE_W-1:0] age_q   [NUM_SETS];

	logic [LINE_W-1:0] line_mem [NUM_LINES];
	logic [LINE_W-1:0] back_mem [MEM_ROWS];
	logic [LINE_W-1:0] line_rdata_q;
	logic [LINE_W-1:0] mem_rdata_q;
	logic [ROW_W-1:0]  clr_cnt_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_hit_q;
	logic              out_dirty_q;

	logic [OFF_W-1:0]  off;
	logic [SET_W-1:0]  set;
	logic [TAG_W-1:0]  tag;
	logic [LIDX_W-1:0] lidx;

	logic [NUM_WAYS-1:0][AGE_W-1:0] aged;
	logic              hit;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  vic_way;
	logic              vic_found;
	logic [AGE_W-1:0]  best_age;
	logic [WAY_W-1:0]  sel_way;
	logic [LINE_W-1:0] merged;
	logic [7:0]        rd_byte;

	assign off  = addr_q[OFF_W-1:0];
	assign set  = addr_q[OFF_W +: SET_W];
	assign tag  = addr_q[ADDR_W-1 -: TAG_W];
	assign lidx = LIDX_W'(int'(set) * NUM_WAYS + int'(way_q));

	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		vic_way   = '0;
		vic_found = 1'b0;
		best_age  = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged[w] = (age_q[set][w] == AGE_MAX) ? AGE_MAX : age_q[set][w] + 1'b1;
			if (!hit && valid_q[set][w] && tag_q[set][w] == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		// invalid way first, else oldest with lowest index on a tie
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!vic_found && !valid_q[set][w]) begin
				vic_found = 1'b1;
				vic_way   = WAY_W'(w);
			end
		end
		if (!vic_found) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (w == 0 || aged[w] > best_age) begin
					best_age = aged[w];
					vic_way  = WAY_W'(w);
				end
			end
		end
		sel_way = hit ? hit_way : vic_way;
	end

	always_comb begin
		merged                = line_rdata_q;
		merged[off*8 +: 8]    = wdata_q;
		rd_byte               = line_rdata_q[off*8 +: 8];
	end

	assign stat.clr_done = (clr_cnt_q == ROW_W'(MEM_ROWS - 1));
	assign stat.hit      = hit;
	assign stat.need_wb  = !hit && valid_q[set][vic_way] && dirty_q[set][vic_way];
	assign stat.is_write = (cmd_q == CMD_WRITE);
	assign stat.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q   <= in_cmd;
			addr_q  <= in_data[ADDR_W-1:0];
			wdata_q <= in_data[ADDR_W +: 8];
		end
		if (cmd.lookup) begin
			way_q     <= sel_way;
			hit_q     <= hit;
			old_tag_q <= tag_q[set][vic_way];
		end
		if (cmd.fill) tag_q[set][way_q] <= tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
				dirty_q[s] <= '0;
				age_q[s]   <= '0;
			end
		end else begin
			if (cmd.lookup) begin
				for (int w = 0; w < NUM_WAYS; w++)
					age_q[set][w] <= (WAY_W'(w) == sel_way) ? '0 : aged[w];
			end
			if (cmd.fill) begin
				valid_q[set][way_q] <= 1'b1;
				dirty_q[set][way_q] <= 1'b0;
			end
			if (cmd.update && cmd_q == CMD_WRITE) dirty_q[set][way_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill)
			line_mem[lidx] <= mem_rdata_q;
		else if (cmd.update && cmd_q == CMD_WRITE)
			line_mem[lidx] <= merged;
		if (cmd.line_rd) line_rdata_q <= line_mem[lidx];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr)
			back_mem[clr_cnt_q] <= '0;
		else if (cmd.mem_wr)
			back_mem[{old_tag_q, set}] <= line_rdata_q;
		if (cmd.mem_rd) mem_rdata_q <= back_mem[addr_q[ADDR_W-1:OFF_W]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (cmd.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.update && cmd_q == CMD_READ) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.update && cmd_q == CMD_READ) begin
			out_byte_q  <= rd_byte;
			out_hit_q   <= hit_q;
			out_dirty_q <= dirty_q[set][way_q];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {6'b0, out_dirty_q, out_hit_q, out_byte_q};

endmodule

// File: hw/rtl/set_assoc_writeback_cache.sv
// Byte-wide cache, 8 sets by 6 ways of 4-byte lines, write-back and
// write-allocate with LRU ages, in front of a 64 KiB line-wide backing memory.
// Slave beat: s_tuser is the access kind (0 read, 1 write), s_tdata carries
// the byte address and the write byte. A read gives one master beat with the
// byte and the hit and dirty flags; a write gives no beat.
// One access at a time: after accept the controller runs lookup, on a dirty
// miss a write-back line read and memory write, on any miss a fill read and
// fill, then a line read and the update step that registers a read's result
// beat; the next slave beat is taken back in idle. The tag lookup, the line
// store port and the backing memory port are each used in turn by the controller.
// After reset, the backing memory's 16384 lines are zeroed one line per cycle;
// s_tready stays low during that sweep and all lines start invalid.
// A stalled master side holds the result in its output register; the block
// then finishes the next read only up to its update step and waits there.
module set_assoc_writeback_cache (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sawbc_pkg::IN_DATA_W-1:0]   s_tdata,  // address[15:0], write_data[23:16]
	input  logic                              s_tuser,  // cmd[0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sawbc_pkg::OUT_DATA_W-1:0]  m_tdata   // read_data[7:0], was_hit[8],
	                                                    // line_dirty[9], zero[15:10]
);
	import sawbc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sawbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sawbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_cmd    (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
